/* rtl/icv_pkg.sv */
// Shared types and constants of the clamped 2D convolution block.
`timescale 1ns / 1ps
package icv_pkg;

  localparam int COL_W  = 11;
  localparam int ROW_W  = 12;
  localparam int WID_W  = 12;
  localparam int HGT_W  = 13;
  localparam int RAD_W  = 2;
  localparam int CH_W   = 3;
  localparam int COEF_W = 16;
  localparam int CIDX_W = 6;
  localparam int SMP_W  = 8;
  localparam int NSMP   = 4;
  localparam int MAX_H  = 4096;
  localparam int QDEPTH = 4;
  localparam int QCNT_W = 3;
  localparam logic [SMP_W-1:0] PIX_MAX = 8'd255;

  typedef enum logic [1:0] {
    CFG_RADIUS = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_CHAN   = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    KIND_COEF  = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_e;

  // Effective (saturated) configuration.
  typedef struct packed {
    logic [2:0]       radius;
    logic [WID_W-1:0] width;
    logic [HGT_W-1:0] height;
    logic [CH_W-1:0]  nch;
  } cfg_t;

  typedef struct packed {
    logic                     is_pix;
    logic [CIDX_W-1:0]        cidx;
    logic signed [COEF_W-1:0] cval;
    logic [NSMP*SMP_W-1:0]    pix;
    logic [COL_W-1:0]         wcol;
    logic [3:0]               wrow;
    logic                     has_out;
    logic [ROW_W-1:0]         rlo;
    logic [ROW_W-1:0]         rhi;
    logic [COL_W-1:0]         clo;
    logic [COL_W-1:0]         chi;
    logic [3:0]               rlo_mod;
  } job_t;

endpackage

/* rtl/icv_front.sv */
// Front end: accepts requests, tracks raster position and classifies each pixel's output run.
`timescale 1ns / 1ps
module icv_front #(
  parameter int MAX_RADIUS = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  icv_pkg::cfg_t                  cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           kind_i,
  input  logic [icv_pkg::CIDX_W-1:0]     coef_index_i,
  input  logic signed [icv_pkg::COEF_W-1:0] coef_value_i,
  input  logic [icv_pkg::NSMP*icv_pkg::SMP_W-1:0] pix_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output icv_pkg::job_t                  job_o
);
  import icv_pkg::*;

  localparam int K = 2 * MAX_RADIUS + 1;

  logic [COL_W-1:0] x_q, x_d, xe;
  logic [ROW_W-1:0] y_q, y_d, ye;
  logic [3:0]       ym_q, ym_d, yme;
  logic [WID_W-1:0] nx;
  logic [HGT_W-1:0] ny;
  logic [ROW_W-1:0] r_row;
  logic [COL_W-1:0] r_col;
  logic             ylast, xlast, rge, cge;
  logic signed [5:0] mt;
  logic             acc_pix;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign acc_pix    = push_o && (kind_i == KIND_PIXEL);

  assign xe  = ({1'b0, x_q} >= cfg_i.width) ? '0 : x_q;
  assign ye  = ({1'b0, y_q} >= cfg_i.height) ? '0 : y_q;
  assign yme = ({1'b0, y_q} >= cfg_i.height) ? '0 : ym_q;

  assign r_row = ROW_W'(cfg_i.radius);
  assign r_col = COL_W'(cfg_i.radius);
  assign ylast = ({1'b0, ye} == cfg_i.height - HGT_W'(1));
  assign xlast = ({1'b0, xe} == cfg_i.width - WID_W'(1));
  assign rge   = ye >= r_row;
  assign cge   = xe >= r_col;
  assign mt    = $signed({2'b00, yme}) - $signed({3'b000, cfg_i.radius});

  always_comb begin
    job_o.is_pix  = (kind_i == KIND_PIXEL);
    job_o.cidx    = coef_index_i;
    job_o.cval    = coef_value_i;
    job_o.pix     = pix_i;
    job_o.wcol    = xe;
    job_o.wrow    = yme;
    job_o.has_out = (ylast || rge) && (xlast || cge);
    job_o.rlo     = rge ? ye - r_row : '0;
    job_o.rhi     = ylast ? ye : ye - r_row;
    job_o.clo     = cge ? xe - r_col : '0;
    job_o.chi     = xlast ? xe : xe - r_col;
    if (!rge) begin
      job_o.rlo_mod = '0;
    end else if (mt < 0) begin
      job_o.rlo_mod = 4'(mt + 6'(K));
    end else begin
      job_o.rlo_mod = 4'(mt);
    end
  end

  assign nx = {1'b0, xe} + WID_W'(1);
  assign ny = {1'b0, ye} + HGT_W'(1);

  always_comb begin
    x_d  = x_q;
    y_d  = y_q;
    ym_d = ym_q;
    if (acc_pix) begin
      if (nx >= cfg_i.width) begin
        x_d = '0;
        if (ny >= cfg_i.height) begin
          y_d  = '0;
          ym_d = '0;
        end else begin
          y_d  = ny[ROW_W-1:0];
          ym_d = (yme == 4'(K - 1)) ? '0 : yme + 4'd1;
        end
      end else begin
        x_d = nx[COL_W-1:0];
        y_d = ye;
        ym_d = yme;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q  <= '0;
      y_q  <= '0;
      ym_q <= '0;
    end else begin
      x_q  <= x_d;
      y_q  <= y_d;
      ym_q <= ym_d;
    end
  end

endmodule

/* rtl/icv_fifo.sv */
// Short request queue between front and back end.
`timescale 1ns / 1ps
module icv_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  icv_pkg::job_t               data_i,
  input  logic                        pop_i,
  output icv_pkg::job_t               data_o,
  output logic                        full_o,
  output logic                        empty_o,
  output logic [icv_pkg::QCNT_W-1:0]  count_o
);
  import icv_pkg::*;

  job_t            mem_q [QDEPTH];
  logic [1:0]      wp_q, rp_q;
  logic [QCNT_W-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + 2'd1;
      if (do_pop)  rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

/* rtl/icv_back.sv */
// Back end: line store, coefficient store and the tap-serial multiply-accumulate sequencer.
`timescale 1ns / 1ps
module icv_back #(
  parameter int MAX_RADIUS = 3,
  parameter int MAX_WIDTH  = 2048,
  parameter int LANES      = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  icv_pkg::cfg_t               cfg_i,
  input  icv_pkg::job_t               job_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [icv_pkg::SMP_W-1:0]   res_o [LANES],
  output logic [icv_pkg::COL_W-1:0]   out_col_o,
  output logic [icv_pkg::ROW_W-1:0]   out_row_o,
  output logic                        last_o
);
  import icv_pkg::*;

  localparam int K     = 2 * MAX_RADIUS + 1;
  localparam int NCOEF = K * K;
  localparam int DEPTH = K * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(NCOEF);
  localparam int LW    = SMP_W * LANES;

  typedef enum logic [1:0] {IDLE, TAP, DRAIN, OUT} state_e;

  state_e state_q;
  logic [LW-1:0]           lmem [DEPTH];
  logic [COEF_W-1:0]       cmem [NCOEF];
  logic [NCOEF-1:0]        cvld_q;
  logic [LW-1:0]           rd_q;
  logic signed [COEF_W-1:0] k_q;
  logic signed [24:0]      prod_q [LANES];
  logic signed [31:0]      acc_q [LANES];
  logic                    v1_q, v2_q, acc_clr;

  logic [ROW_W-1:0] oy_q, rhi_q;
  logic [COL_W-1:0] ox_q, clo_q, chi_q;
  logic [3:0]       oym_q, kx_q, ky_q, side_m1;
  logic [CW-1:0]    ci_q;
  logic             tap_en;

  logic signed [13:0] ty, tx, dy;
  logic [ROW_W-1:0]   sy;
  logic [WID_W-1:0]   sx;
  logic signed [5:0]  m6;
  logic [3:0]         rowm;
  logic [AW-1:0]      raddr, waddr;
  logic               wr_pix, wr_coef;
  logic [SMP_W-1:0]   rnd [LANES];

  assign side_m1 = {cfg_i.radius, 1'b0};
  assign pop_o   = (state_q == IDLE) && !empty_i;
  assign wr_pix  = pop_o && job_i.is_pix;
  assign wr_coef = pop_o && !job_i.is_pix && (int'(job_i.cidx) < NCOEF);
  assign tap_en  = (state_q == TAP);

  // Tap address with replicated borders.
  always_comb begin
    ty = $signed({2'b00, oy_q}) + $signed({10'b0, ky_q}) - $signed({11'b0, cfg_i.radius});
    tx = $signed({3'b000, ox_q}) + $signed({10'b0, kx_q}) - $signed({11'b0, cfg_i.radius});
    if (ty < 0) begin
      sy = '0;
    end else if (ty > $signed({1'b0, cfg_i.height}) - 14'sd1) begin
      sy = ROW_W'(cfg_i.height - HGT_W'(1));
    end else begin
      sy = ty[ROW_W-1:0];
    end
    if (tx < 0) begin
      sx = '0;
    end else if (tx > $signed({2'b00, cfg_i.width}) - 14'sd1) begin
      sx = cfg_i.width - WID_W'(1);
    end else begin
      sx = tx[WID_W-1:0];
    end
    dy = $signed({2'b00, sy}) - $signed({2'b00, oy_q});
    m6 = $signed({2'b00, oym_q}) + 6'(dy);
    if (m6 < 0) begin
      rowm = 4'(m6 + 6'(K));
    end else if (m6 >= 6'(K)) begin
      rowm = 4'(m6 - 6'(K));
    end else begin
      rowm = 4'(m6);
    end
    raddr = AW'(int'(rowm) * MAX_WIDTH + int'(sx));
    waddr = AW'(int'(job_i.wrow) * MAX_WIDTH + int'(job_i.wcol));
  end

  always_ff @(posedge clk_i) begin
    if (wr_pix) begin
      lmem[waddr] <= job_i.pix[LW-1:0];
    end
    rd_q <= lmem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_coef) begin
      cmem[CW'(job_i.cidx)] <= job_i.cval;
    end
    k_q <= cvld_q[ci_q] ? $signed(cmem[ci_q]) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvld_q <= '0;
    end else if (wr_coef) begin
      cvld_q[CW'(job_i.cidx)] <= 1'b1;
    end
  end

  for (genvar c = 0; c < LANES; c++) begin : g_lane
    always_ff @(posedge clk_i) begin
      prod_q[c] <= $signed({1'b0, rd_q[c*SMP_W +: SMP_W]}) * k_q;
      if (acc_clr) begin
        acc_q[c] <= '0;
      end else if (v2_q) begin
        acc_q[c] <= acc_q[c] + 32'(prod_q[c]);
      end
    end
    logic signed [31:0] q;
    always_comb begin
      q = (acc_q[c] + 32'sd128) >>> 8;
      if (c >= int'(cfg_i.nch) || acc_q[c] < 0) begin
        rnd[c] = '0;
      end else if (q > 32'sd255) begin
        rnd[c] = PIX_MAX;
      end else begin
        rnd[c] = q[SMP_W-1:0];
      end
    end
  end

  assign acc_clr = (state_q == IDLE) || (state_q == OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_o <= 1'b0;
      last_o      <= 1'b0;
      out_col_o   <= '0;
      out_row_o   <= '0;
      oy_q <= '0; ox_q <= '0; rhi_q <= '0; clo_q <= '0; chi_q <= '0;
      oym_q <= '0; kx_q <= '0; ky_q <= '0; ci_q <= '0;
      for (int c = 0; c < LANES; c++) res_o[c] <= '0;
    end else begin
      v1_q <= tap_en;
      v2_q <= v1_q;
      unique case (state_q)
        IDLE: begin
          if (wr_pix && job_i.has_out) begin
            oy_q  <= job_i.rlo;
            rhi_q <= job_i.rhi;
            ox_q  <= job_i.clo;
            clo_q <= job_i.clo;
            chi_q <= job_i.chi;
            oym_q <= job_i.rlo_mod;
            kx_q  <= '0;
            ky_q  <= '0;
            ci_q  <= '0;
            state_q <= TAP;
          end
        end
        TAP: begin
          ci_q <= ci_q + CW'(1);
          if (kx_q == side_m1) begin
            kx_q <= '0;
            if (ky_q == side_m1) begin
              state_q <= DRAIN;
            end else begin
              ky_q <= ky_q + 4'd1;
            end
          end else begin
            kx_q <= kx_q + 4'd1;
          end
        end
        DRAIN: begin
          if (!v1_q && !v2_q) begin
            for (int c = 0; c < LANES; c++) res_o[c] <= rnd[c];
            out_col_o   <= ox_q;
            out_row_o   <= oy_q;
            last_o      <= (ox_q == chi_q) && (oy_q == rhi_q);
            out_valid_o <= 1'b1;
            state_q     <= OUT;
          end
        end
        OUT: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            kx_q <= '0;
            ky_q <= '0;
            ci_q <= '0;
            if (last_o) begin
              state_q <= IDLE;
            end else begin
              state_q <= TAP;
              if (ox_q == chi_q) begin
                ox_q  <= clo_q;
                oy_q  <= oy_q + ROW_W'(1);
                oym_q <= (oym_q == 4'(K - 1)) ? '0 : oym_q + 4'd1;
              end else begin
                ox_q <= ox_q + COL_W'(1);
              end
            end
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

endmodule

/* rtl/image_convolution_2d_clamped.sv */
// Top level of the streaming 2D convolution with replicated borders.
`timescale 1ns / 1ps
// Requests are either coefficient loads or raster-ordered pixels; they enter a four-entry
// queue at up to one per cycle and are executed in order by a single tap-serial engine.
// A coefficient load or a pixel that completes no output is retired without starting the
// engine. Each output is accumulated one kernel tap per cycle through the one line-store
// read port; then the pipeline drains and the result is handed off and held until taken; a
// pixel causes up to (r+1)^2 outputs. Results are rounded half away from zero and clamped
// to 0..255.
module image_convolution_2d_clamped #(
  parameter int MAX_RADIUS = 3,
  parameter int MAX_WIDTH  = 2048,
  parameter int LANES      = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic [icv_pkg::HGT_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              in_kind_i,
  input  logic [icv_pkg::CIDX_W-1:0]        in_coef_index_i,
  input  logic signed [icv_pkg::COEF_W-1:0] in_coef_value_i,
  input  logic [icv_pkg::SMP_W-1:0]         in_sample0_i,
  input  logic [icv_pkg::SMP_W-1:0]         in_sample1_i,
  input  logic [icv_pkg::SMP_W-1:0]         in_sample2_i,
  input  logic [icv_pkg::SMP_W-1:0]         in_sample3_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [icv_pkg::SMP_W-1:0]         out_result0_o,
  output logic [icv_pkg::SMP_W-1:0]         out_result1_o,
  output logic [icv_pkg::SMP_W-1:0]         out_result2_o,
  output logic [icv_pkg::SMP_W-1:0]         out_result3_o,
  output logic [icv_pkg::COL_W-1:0]         out_out_col_o,
  output logic [icv_pkg::ROW_W-1:0]         out_out_row_o,
  output logic                              out_last_of_run_o
);
  import icv_pkg::*;

  logic [RAD_W-1:0] rad_q;
  logic [WID_W-1:0] wid_q;
  logic [HGT_W-1:0] hgt_q;
  logic [CH_W-1:0]  nch_q;
  cfg_t             cfg;
  job_t             fjob, qjob;
  logic             push, pop, q_full, q_empty;
  logic [QCNT_W-1:0] q_count;
  logic [SMP_W-1:0] res [LANES];
  logic [SMP_W-1:0] res4 [NSMP];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q <= 2'd1;
      wid_q <= 12'd640;
      hgt_q <= 13'd480;
      nch_q <= 3'd3;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_RADIUS: rad_q <= cfg_data_i[RAD_W-1:0];
        CFG_WIDTH:  wid_q <= cfg_data_i[WID_W-1:0];
        CFG_HEIGHT: hgt_q <= cfg_data_i;
        CFG_CHAN:   nch_q <= cfg_data_i[CH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.radius = (int'(rad_q) > MAX_RADIUS) ? 3'(MAX_RADIUS) : 3'(rad_q);
    if (wid_q == '0) cfg.width = WID_W'(1);
    else if (int'(wid_q) > MAX_WIDTH) cfg.width = WID_W'(MAX_WIDTH);
    else cfg.width = wid_q;
    if (hgt_q == '0) cfg.height = HGT_W'(1);
    else if (int'(hgt_q) > MAX_H) cfg.height = HGT_W'(MAX_H);
    else cfg.height = hgt_q;
    if (nch_q == '0) cfg.nch = CH_W'(1);
    else if (int'(nch_q) > LANES) cfg.nch = CH_W'(LANES);
    else cfg.nch = nch_q;
  end

  icv_front #(.MAX_RADIUS(MAX_RADIUS)) u_front (
    .clk_i, .rst_ni,
    .cfg_i        (cfg),
    .in_valid_i,
    .in_ready_o,
    .kind_i       (in_kind_i),
    .coef_index_i (in_coef_index_i),
    .coef_value_i (in_coef_value_i),
    .pix_i        ({in_sample3_i, in_sample2_i, in_sample1_i, in_sample0_i}),
    .q_full_i     (q_full),
    .push_o       (push),
    .job_o        (fjob)
  );

  icv_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  (fjob),
    .pop_i   (pop),
    .data_o  (qjob),
    .full_o  (q_full),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  icv_back #(.MAX_RADIUS(MAX_RADIUS), .MAX_WIDTH(MAX_WIDTH), .LANES(LANES)) u_back (
    .clk_i, .rst_ni,
    .cfg_i       (cfg),
    .job_i       (qjob),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o,
    .out_ready_i,
    .res_o       (res),
    .out_col_o   (out_out_col_o),
    .out_row_o   (out_out_row_o),
    .last_o      (out_last_of_run_o)
  );

  for (genvar c = 0; c < NSMP; c++) begin : g_res
    if (c < LANES) begin : g_used
      assign res4[c] = res[c];
    end else begin : g_zero
      assign res4[c] = '0;
    end
  end

  assign out_result0_o = res4[0];
  assign out_result1_o = res4[1];
  assign out_result2_o = res4[2];
  assign out_result3_o = res4[3];

  a_qcount: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QCNT_W'(QDEPTH))
    else $error("request queue overflow");

  a_qfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(q_count) == QCNT_W'(QDEPTH - 1))
    else $error("queue filled without a single push");

  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty && !out_valid_o)
    else $error("pop while queue empty or result pending");

endmodule
